FILE: sv/pbrq_pkg.sv
// ----------------------------------------------------------------------------
// pbrq_pkg
// shared constants, codes and control structs of the packet byte ring queue
// ----------------------------------------------------------------------------
package pbrq_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned MAX_GET = 64;

  // ring index, wide scratch for space math, get counter
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned OW   = AW + 8;
  localparam int unsigned CNTW = $clog2(MAX_GET + 1);

  localparam logic [1:0] FN_BEGIN = 2'd0;
  localparam logic [1:0] FN_PUT   = 2'd1;
  localparam logic [1:0] FN_GET   = 2'd2;

  localparam logic [1:0] KD_VERDICT = 2'd0;
  localparam logic [1:0] KD_PUT_ACK = 2'd1;
  localparam logic [1:0] KD_BYTE    = 2'd2;
  localparam logic [1:0] KD_NONE    = 2'd3;

  typedef struct packed {
    logic in_ready;
    logic do_begin;
    logic do_put;
    logic do_get_start;
    logic do_get_none;
    logic rd_issue;
    logic get_load;
  } pbrq_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] func;
    logic       out_free;
    logic       get_empty;
    logic       cnt_one;
  } pbrq_sts_t;

endpackage

FILE: sv/pbrq_if.sv
// ----------------------------------------------------------------------------
// pbrq channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface pbrq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic [7:0] amount;

  modport source (output valid, output func, output data_byte, output amount, input ready);
  modport sink   (input valid, input func, input data_byte, input amount, output ready);
endinterface

interface pbrq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte_out;
  logic       accepted;
  logic       last;
  logic [7:0] free_space;

  modport source (output valid, output kind, output data_byte_out, output accepted,
                  output last, output free_space, input ready);
  modport sink   (input valid, input kind, input data_byte_out, input accepted,
                  input last, input free_space, output ready);
endinterface

FILE: sv/pbrq_ram.sv
// ----------------------------------------------------------------------------
// pbrq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pbrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pbrq_ctrl.sv
// ----------------------------------------------------------------------------
// pbrq_ctrl
// sequencer: takes items while idle, steps a get run through read and load
// ----------------------------------------------------------------------------
module pbrq_ctrl import pbrq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pbrq_sts_t sts_i,
  output pbrq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == ST_IDLE) && sts_i.out_free;
    accept         = cmd_o.in_ready && sts_i.in_valid;
    cmd_o.do_begin = accept && (sts_i.func == FN_BEGIN);
    cmd_o.do_put   = accept && (sts_i.func == FN_PUT);
    cmd_o.do_get_start = accept && (sts_i.func == FN_GET) && !sts_i.get_empty;
    cmd_o.do_get_none  = accept && (sts_i.func == FN_GET) && sts_i.get_empty;
    cmd_o.rd_issue = (state_q == ST_READ);
    cmd_o.get_load = (state_q == ST_LOAD) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.do_get_start) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (cmd_o.get_load) state_d = sts_i.cnt_one ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // no new item while a get run is in flight
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_o.in_ready)
    else $error("item taken during get run");

  // a read is always followed by its load state
  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> (state_q == ST_LOAD))
    else $error("read not followed by load");

endmodule

FILE: sv/pbrq_dp.sv
// ----------------------------------------------------------------------------
// pbrq_dp
// ring indices, packet admission state, get counter, byte ram, result register
// ----------------------------------------------------------------------------
module pbrq_dp import pbrq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pbrq_cmd_t  cmd_i,
  output pbrq_sts_t  sts_o,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] amount_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_out_o,
  output logic       accepted_o,
  output logic       last_o,
  output logic [7:0] free_space_o
);

  function automatic logic [OW-1:0] occ_f(input logic [AW-1:0] wr, input logic [AW-1:0] rd);
    logic [OW-1:0] w, r;
    w = OW'(wr);
    r = OW'(rd);
    return (wr >= rd) ? (w - r) : (w + OW'(DEPTH) - r);
  endfunction

  function automatic logic [AW-1:0] inc_f(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic            open_q, open_d;
  logic [7:0]      left_q, left_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic            oval_q, oval_d;
  logic [1:0]      okind_q, okind_d;
  logic [7:0]      odata_q, odata_d;
  logic            oacc_q, oacc_d;
  logic            olast_q, olast_d;
  logic [7:0]      ofree_q, ofree_d;

  logic [OW-1:0]   occ_now, free_now, occ_next, free_next;
  logic [CNTW-1:0] want, n_get;
  logic            put_ok, adm_ok, out_free, we;
  logic [7:0]      rdata;

  assign out_free = !oval_q || out_ready_i;
  assign occ_now  = occ_f(wr_q, rd_q);
  assign free_now = OW'(DEPTH - 1) - occ_now;
  assign adm_ok   = free_now >= OW'(amount_i);
  assign put_ok   = open_q && (left_q != 8'd0);
  assign want     = (amount_i > 8'(MAX_GET)) ? CNTW'(MAX_GET) : amount_i[CNTW-1:0];
  assign n_get    = (OW'(want) < occ_now) ? want : occ_now[CNTW-1:0];
  assign we       = cmd_i.do_put && put_ok;

  always_comb begin
    sts_o.in_valid  = in_valid_i;
    sts_o.func      = func_i;
    sts_o.out_free  = out_free;
    sts_o.get_empty = (n_get == '0);
    sts_o.cnt_one   = (cnt_q == CNTW'(1));
  end

  pbrq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_q),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // ring and packet state
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    open_d = open_q;
    left_d = left_q;
    cnt_d  = cnt_q;
    if (cmd_i.do_begin) begin
      open_d = adm_ok && (amount_i != 8'd0);
      left_d = open_d ? amount_i : 8'd0;
    end
    if (cmd_i.do_put) begin
      if (put_ok) begin
        wr_d   = inc_f(wr_q);
        left_d = left_q - 8'd1;
        open_d = (left_q != 8'd1);
      end else begin
        open_d = 1'b0;
        left_d = 8'd0;
      end
    end
    if (cmd_i.do_get_start) cnt_d = n_get;
    if (cmd_i.get_load) begin
      rd_d  = inc_f(rd_q);
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  assign occ_next  = occ_f(wr_d, rd_d);
  assign free_next = OW'(DEPTH - 1) - occ_next;

  // result register
  always_comb begin
    oval_d  = oval_q && !out_ready_i;
    okind_d = okind_q;
    odata_d = odata_q;
    oacc_d  = oacc_q;
    olast_d = olast_q;
    ofree_d = (free_next > OW'(255)) ? 8'hFF : free_next[7:0];
    if (cmd_i.do_begin || cmd_i.do_put || cmd_i.do_get_none || cmd_i.get_load) begin
      oval_d  = 1'b1;
      odata_d = 8'd0;
      olast_d = 1'b0;
      priority if (cmd_i.do_begin) begin
        okind_d = KD_VERDICT;
        oacc_d  = adm_ok;
      end else if (cmd_i.do_put) begin
        okind_d = KD_PUT_ACK;
        oacc_d  = put_ok;
      end else if (cmd_i.do_get_none) begin
        okind_d = KD_NONE;
        oacc_d  = 1'b0;
        olast_d = 1'b1;
      end else begin
        okind_d = KD_BYTE;
        odata_d = rdata;
        oacc_d  = 1'b1;
        olast_d = (cnt_q == CNTW'(1));
      end
    end else begin
      ofree_d = ofree_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      open_q <= 1'b0;
      left_q <= '0;
      cnt_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      open_q <= open_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    odata_q <= odata_d;
    oacc_q  <= oacc_d;
    olast_q <= olast_d;
    ofree_q <= ofree_d;
  end

  assign out_valid_o     = oval_q;
  assign kind_o          = okind_q;
  assign data_byte_out_o = odata_q;
  assign accepted_o      = oacc_q;
  assign last_o          = olast_q;
  assign free_space_o    = ofree_q;

  a_open_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (left_q != 8'd0))
    else $error("open packet with no bytes left");

  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.get_load |-> (cnt_q != '0))
    else $error("get load with zero count");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.get_load |=> (oval_q && (okind_q == KD_BYTE)))
    else $error("loaded get byte not presented");

  a_last_byte_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_put && open_q && (left_q == 8'd1)) |=> !open_q)
    else $error("packet still open after final byte");

endmodule

FILE: sv/packet_byte_ring_queue_core.sv
// ----------------------------------------------------------------------------
// packet_byte_ring_queue_core
// put-begin, put-byte: result registered the cycle after the transfer; func 3
//   items are taken with no result; a new item is taken whenever the result slot
//   frees and no get run is in flight; get: per byte a ram read, then a load
//   into the result register once the slot is free; empty gets give a none result
// async active-low reset clears indices, packet state and result valid; the
//   byte ram is not cleared and is only read at slots already written
// ----------------------------------------------------------------------------
module packet_byte_ring_queue_core import pbrq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbrq_in_if.sink     in_i,
  pbrq_out_if.source  out_o
);

  // command and status between sequencer and datapath
  pbrq_cmd_t cmd;
  pbrq_sts_t sts;

  // sequencer owns the input ready and the get run steps
  pbrq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  assign in_i.ready = cmd.in_ready;

  // datapath holds the ring, packet admission and the result register
  pbrq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_i.valid),
    .func_i          (in_i.func),
    .data_byte_i     (in_i.data_byte),
    .amount_i        (in_i.amount),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .kind_o          (out_o.kind),
    .data_byte_out_o (out_o.data_byte_out),
    .accepted_o      (out_o.accepted),
    .last_o          (out_o.last),
    .free_space_o    (out_o.free_space)
  );

  // a stalled result transfer keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("result dropped while stalled");

  // input ready never rises while a result is stuck
  a_ready_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!out_o.valid || out_o.ready))
    else $error("input ready with result slot full");

endmodule
